### sv/b58d_pkg.sv
// Shared types, constants and the base-58 character decode for the
// base-58 identifier string decoder. No dependencies.
package b58d_pkg;

    localparam int STRING_LENGTH = 90;
    localparam int VALUE_WORDS   = 8;

    localparam int WORD_W  = 64;
    localparam int ACC_W   = VALUE_WORDS * WORD_W;
    localparam int RADIX_W = 6;
    localparam int CNT_W   = 8;
    localparam int IDX_W   = (VALUE_WORDS > 1) ? $clog2(VALUE_WORDS) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [7:0]       CHAR_C  = 8'h63;
    localparam logic [7:0]       CHAR_4  = 8'h34;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LEN    = 3'd1,
        ST_PREFIX = 3'd2,
        ST_CHAR   = 3'd3,
        ST_OVF    = 3'd4
    } t_status;

    // one classified character, front to back
    typedef struct packed {
        logic                fold;
        logic [RADIX_W-1:0]  digit;
        logic                last;
        t_status             status;
    } t_cls;

    // finished string, back to emitter
    typedef struct packed {
        t_status             status;
        logic [ACC_W-1:0]    value;
    } t_load;

    // {valid, digit}
    function automatic logic [RADIX_W:0] digit_of(input logic [7:0] b);
        logic [RADIX_W:0] r;
        r = '0;
        if (b >= 8'h31 && b <= 8'h39) begin
            r = {1'b1, RADIX_W'(b - 8'h31)};
        end else if (b >= 8'h41 && b <= 8'h48) begin
            r = {1'b1, RADIX_W'(b - 8'h41 + 8'd9)};
        end else if (b >= 8'h4A && b <= 8'h4E) begin
            r = {1'b1, RADIX_W'(b - 8'h4A + 8'd17)};
        end else if (b >= 8'h50 && b <= 8'h5A) begin
            r = {1'b1, RADIX_W'(b - 8'h50 + 8'd22)};
        end else if (b >= 8'h61 && b <= 8'h6B) begin
            r = {1'b1, RADIX_W'(b - 8'h61 + 8'd33)};
        end else if (b >= 8'h6D && b <= 8'h7A) begin
            r = {1'b1, RADIX_W'(b - 8'h6D + 8'd44)};
        end
        return r;
    endfunction

endpackage

### sv/b58d_front.sv
// Input side: counts characters, checks prefix and alphabet, tracks
// sticky errors and emits one classified entry per character. Uses b58d_pkg.
module b58d_front import b58d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_ready,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_cls       o_entry
);

    logic [CNT_W-1:0] r_count;
    logic             r_prefix_bad;
    logic             r_char_bad;

    logic [CNT_W-1:0] n_count;
    logic             n_prefix_bad;
    logic             n_char_bad;
    logic [RADIX_W:0] dig;

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_comb begin
        dig           = digit_of(i_char);
        n_prefix_bad  = r_prefix_bad;
        n_char_bad    = r_char_bad;
        o_entry.fold  = 1'b0;
        o_entry.digit = dig[RADIX_W-1:0];
        o_entry.last  = i_last;
        if (r_count == CNT_W'(0)) begin
            n_prefix_bad = r_prefix_bad || (i_char != CHAR_C);
        end else if (r_count == CNT_W'(1)) begin
            n_prefix_bad = r_prefix_bad || (i_char != CHAR_4);
        end else if (r_count < CNT_W'(STRING_LENGTH)) begin
            if (dig[RADIX_W]) begin
                o_entry.fold = 1'b1;
            end else begin
                n_char_bad = 1'b1;
            end
        end
        n_count = (r_count == CNT_MAX) ? r_count : r_count + CNT_W'(1);
        if (n_count != CNT_W'(STRING_LENGTH)) begin
            o_entry.status = ST_LEN;
        end else if (n_prefix_bad) begin
            o_entry.status = ST_PREFIX;
        end else if (n_char_bad) begin
            o_entry.status = ST_CHAR;
        end else begin
            o_entry.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_prefix_bad <= 1'b0;
            r_char_bad   <= 1'b0;
        end else if (o_push) begin
            if (i_last) begin
                r_count      <= '0;
                r_prefix_bad <= 1'b0;
                r_char_bad   <= 1'b0;
            end else begin
                r_count      <= n_count;
                r_prefix_bad <= n_prefix_bad;
                r_char_bad   <= n_char_bad;
            end
        end
    end

endmodule

### sv/b58d_fifo.sv
// Short queue of classified characters between front and back.
// Uses b58d_pkg.
module b58d_fifo import b58d_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_entry,
    output logic o_ready,
    output logic o_valid,
    output t_cls o_entry,
    input  logic i_pop
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_fill;

    assign o_ready = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (QPTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (QPTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### sv/b58d_back.sv
// Back side: folds digits into the wide accumulator (acc*58 + digit as
// shift-add), tracks overflow and hands finished strings to the emitter.
// Uses b58d_pkg.
module b58d_back import b58d_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cls  i_entry,
    output logic  o_pop,
    output logic  o_load_valid,
    output t_load o_load,
    input  logic  i_load_ready
);

    localparam int EXT_W = ACC_W + RADIX_W;

    logic [ACC_W-1:0] r_acc;
    logic             r_ovf;

    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] prod;
    logic [ACC_W-1:0] n_acc;
    logic             n_ovf;

    always_comb begin
        ext   = EXT_W'(r_acc);
        prod  = (ext << 6) - (ext << 3) + (ext << 1) + EXT_W'(i_entry.digit);
        n_acc = r_acc;
        n_ovf = r_ovf;
        if (i_entry.fold) begin
            n_acc = prod[ACC_W-1:0];
            n_ovf = r_ovf || (prod[EXT_W-1:ACC_W] != '0);
        end
    end

    assign o_pop        = i_valid && (!i_entry.last || i_load_ready);
    assign o_load_valid = i_valid && i_entry.last;
    assign o_load.value = n_acc;
    assign o_load.status = (i_entry.status != ST_OK) ? i_entry.status :
                           (n_ovf ? ST_OVF : ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (o_pop) begin
            if (i_entry.last) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

### sv/b58d_emit.sv
// Output register: holds a finished string and sends it as value words,
// most significant first. Uses b58d_pkg.
module b58d_emit import b58d_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  t_load             i_load,
    output logic              o_load_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_word,
    output logic [2:0]        o_index,
    output t_status           o_status,
    output logic              o_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_WORDS - 1);

    logic             r_busy;
    logic [ACC_W-1:0] r_buf;
    t_status          r_status;
    logic [IDX_W-1:0] r_idx;

    logic take;
    logic load;

    assign take         = r_busy && i_ready;
    assign o_load_ready = !r_busy || (take && r_idx == LAST_IDX);
    assign load         = i_load_valid && o_load_ready;

    assign o_valid  = r_busy;
    assign o_word   = r_buf[ACC_W-1 -: WORD_W];
    assign o_index  = 3'(r_idx);
    assign o_status = r_status;
    assign o_last   = (r_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            r_busy <= (r_idx != LAST_IDX);
            r_idx  <= (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf    <= (i_load.status == ST_OK) ? i_load.value : '0;
            r_status <= i_load.status;
        end else if (take) begin
            r_buf <= r_buf << WORD_W;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_status != ST_OK) |-> (o_word == '0))
        else $error("nonzero word on failed string");

    a_start_msw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_idx == '0))
        else $error("string does not start at word zero");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_busy) |-> (take && r_idx == LAST_IDX))
        else $error("load overran unsent words");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("word index not cleared while idle");

endmodule

### sv/base58_id_string_decoder.sv
// Top level of the base-58 identifier string decoder: front, queue, back
// and output emitter. Uses b58d_pkg and the b58d_* modules.
//
// Takes one character per cycle, sustained. Each string ending in tlast
// gives VALUE_WORDS output transfers, one per cycle while tready is high,
// most significant word first; the emitter sends them from its own buffer
// while the accumulator already folds the next string. A string's final
// character reaches the output the cycle after it leaves the 4-entry queue;
// input stalls only when strings shorter than about VALUE_WORDS characters
// arrive back to back, or when the output side stalls long enough to fill
// the queue. The digit fold is a shift-add over the 512-bit accumulator.
module base58_id_string_decoder import b58d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_string
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [63:0] value_word, [66:64] word_index
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast    // last_word
);

    logic  q_ready;
    logic  push;
    t_cls  push_entry;
    logic  q_valid;
    t_cls  q_entry;
    logic  pop;
    logic  load_valid;
    logic  load_ready;
    t_load load;

    logic [WORD_W-1:0] word;
    logic [2:0]        index;
    t_status           status;

    b58d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    b58d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    b58d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_entry      (q_entry),
        .o_pop        (pop),
        .o_load_valid (load_valid),
        .o_load       (load),
        .i_load_ready (load_ready)
    );

    b58d_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (load_valid),
        .i_load       (load),
        .o_load_ready (load_ready),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_word       (word),
        .o_index      (index),
        .o_status     (status),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {5'b0, index, word};
    assign o_m_axis_tuser = status;

endmodule
